>>> hdl/strict_decimal_int64_parser_macros.svh
// Assertion macros for the strict decimal int64 parser checker.
// Depends on nothing; included by files that assert.
`ifndef STRICT_DECIMAL_INT64_PARSER_MACROS_SVH
`define STRICT_DECIMAL_INT64_PARSER_MACROS_SVH

// same-cycle implication
`define SDI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SDI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/sdi_pkg.sv
// Package for the strict decimal int64 parser: constants and word types.
// Depends on nothing.
`default_nettype none
package sdi_pkg;

   localparam int MAX_DIGITS         = 20;
   localparam int COUNT_BITS         = $clog2(MAX_DIGITS + 1);
   localparam int INDEX_BITS_DEFAULT = 32;
   localparam int VALUE_BITS         = 64;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       byte_present;
      logic       end_of_element;
   } req_word_type;

   typedef struct packed {
      logic                          is_number;
      logic signed [VALUE_BITS-1:0] parsed_value;
   } rsp_word_type;

endpackage
`default_nettype wire

>>> hdl/sdi_req_if.sv
// Input channel: one character word per handshake.
// Depends on nothing.
`default_nettype none
interface sdi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       byte_present;
   logic       end_of_element;

   modport source (output valid, char_byte, byte_present, end_of_element, input ready);
   modport sink   (input valid, char_byte, byte_present, end_of_element, output ready);
endinterface
`default_nettype wire

>>> hdl/sdi_rsp_if.sv
// Result channel: one parsed element word per handshake.
// Depends on nothing.
`default_nettype none
interface sdi_rsp_if #(
   parameter int INDEX_BITS = 32
);
   logic                   valid;
   logic                   ready;
   logic                   is_number;
   logic signed [63:0]     parsed_value;
   logic [INDEX_BITS-1:0]  element_number;

   modport source (output valid, is_number, parsed_value, element_number, input ready);
   modport sink   (input valid, is_number, parsed_value, element_number, output ready);
endinterface
`default_nettype wire

>>> hdl/sdi_in_stage.sv
// Input register stage of the parser.
// Depends on sdi_pkg.
`default_nettype none
module sdi_in_stage
   import sdi_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   input  wire logic         advance,
   output logic              word_valid,
   output req_word_type      word
);

   logic         valid_ff, valid_in;
   req_word_type word_ff;
   logic         take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= req_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule
`default_nettype wire

>>> hdl/sdi_element.sv
// Per-element parse state: digit accumulate, canonical checks, close.
// Depends on sdi_pkg.
`default_nettype none
module sdi_element
   import sdi_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_word_type    word,
   input  wire logic            advance,
   output logic                 closes,
   output rsp_word_type         result,
   output logic [INDEX_BITS-1:0] index
);

   logic [VALUE_BITS-1:0] acc_ff, acc_in, acc_t;
   logic [COUNT_BITS-1:0] count_ff, count_in, count_t;
   logic                  minus_ff, minus_in, minus_t;
   logic                  bad_ff, bad_in, bad_t;
   logic                  lz_ff, lz_in, lz_t;
   logic [INDEX_BITS-1:0] index_ff, index_in;

   logic [VALUE_BITS+3:0] wide;
   logic [3:0]            digit;
   logic                  first;
   logic [VALUE_BITS-1:0] mag_s;
   logic                  minus_s, bad_s, ok;
   logic [COUNT_BITS-1:0] count_s;

   assign digit = word.char_byte[3:0];
   assign wide  = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                  + {{VALUE_BITS{1'b0}}, digit};
   assign first = (count_ff == '0) && !minus_ff && !bad_ff;

   // one byte into the element
   always_comb begin
      acc_t   = acc_ff;
      count_t = count_ff;
      minus_t = minus_ff;
      bad_t   = bad_ff;
      lz_t    = lz_ff;
      if (!bad_ff) begin
         if (word.char_byte == CHAR_MINUS) begin
            if (first) begin
               minus_t = 1'b1;
            end else begin
               bad_t = 1'b1;
            end
         end else if (!(word.char_byte inside {[CHAR_ZERO:CHAR_NINE]})) begin
            bad_t = 1'b1;
         end else if (lz_ff || (count_ff >= COUNT_BITS'(MAX_DIGITS))) begin
            bad_t = 1'b1;
         end else if ((count_ff == '0) && (digit == 4'd0) && minus_ff) begin
            bad_t = 1'b1;
         end else begin
            if ((count_ff == '0) && (digit == 4'd0)) begin
               lz_t = 1'b1;
            end
            if (wide[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
               bad_t = 1'b1;
            end else begin
               acc_t   = wide[VALUE_BITS-1:0];
               count_t = count_ff + COUNT_BITS'(1);
            end
         end
      end
   end

   assign closes  = !word.byte_present || word.end_of_element;
   assign mag_s   = word.byte_present ? acc_t   : acc_ff;
   assign count_s = word.byte_present ? count_t : count_ff;
   assign minus_s = word.byte_present ? minus_t : minus_ff;
   assign bad_s   = word.byte_present ? bad_t   : bad_ff;

   // int64 range: magnitude up to 2^63 with minus, below 2^63 without
   always_comb begin
      ok = !bad_s && (count_s != '0);
      if (minus_s) begin
         if (mag_s[VALUE_BITS-1] && (mag_s[VALUE_BITS-2:0] != '0)) begin
            ok = 1'b0;
         end
      end else if (mag_s[VALUE_BITS-1]) begin
         ok = 1'b0;
      end
      result.is_number = ok;
      if (!ok) begin
         result.parsed_value = '0;
      end else if (minus_s) begin
         result.parsed_value = -$signed(mag_s);
      end else begin
         result.parsed_value = $signed(mag_s);
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      count_in = count_ff;
      minus_in = minus_ff;
      bad_in   = bad_ff;
      lz_in    = lz_ff;
      index_in = index_ff;
      if (advance) begin
         if (closes) begin
            acc_in   = '0;
            count_in = '0;
            minus_in = 1'b0;
            bad_in   = 1'b0;
            lz_in    = 1'b0;
            index_in = index_ff + INDEX_BITS'(1);
         end else begin
            acc_in   = acc_t;
            count_in = count_t;
            minus_in = minus_t;
            bad_in   = bad_t;
            lz_in    = lz_t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         count_ff <= '0;
         minus_ff <= 1'b0;
         bad_ff   <= 1'b0;
         lz_ff    <= 1'b0;
         index_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         count_ff <= count_in;
         minus_ff <= minus_in;
         bad_ff   <= bad_in;
         lz_ff    <= lz_in;
         index_ff <= index_in;
      end
   end

   assign index = index_ff;

endmodule
`default_nettype wire

>>> hdl/sdi_out_stage.sv
// Result register stage of the parser.
// Depends on sdi_pkg.
`default_nettype none
module sdi_out_stage
   import sdi_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire rsp_word_type          result,
   input  wire logic [INDEX_BITS-1:0] index,
   output logic                       free,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_word_type               rsp_word,
   output logic [INDEX_BITS-1:0]      rsp_index
);

   logic                  valid_ff, valid_in;
   rsp_word_type          word_ff;
   logic [INDEX_BITS-1:0] index_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff  <= result;
         index_ff <= index;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;
   assign rsp_index = index_ff;

endmodule
`default_nettype wire

>>> hdl/strict_decimal_int64_parser.sv
// Top level of the strict decimal int64 parser.
// Depends on sdi_pkg, sdi_req_if, sdi_rsp_if, sdi_in_stage, sdi_element, sdi_out_stage.
//
//   channel    direction  word
//   req_chan   in         char_byte, byte_present, end_of_element
//   rsp_chan   out        is_number, parsed_value, element_number
//
// One word per cycle is accepted unless a closing word waits on a stalled result; a closing word
// passes the input register stage, and its result the result register stage, before it leaves.
// Synchronous reset empties both register stages and zeroes the element index.
// A stalled result holds the input stage only when that stage's word closes an element.
`default_nettype none
module strict_decimal_int64_parser
   import sdi_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   sdi_req_if.sink   req_chan,
   sdi_rsp_if.source rsp_chan
);

   req_word_type          req_word;
   req_word_type          word;
   logic                  word_valid;
   logic                  advance;
   logic                  closes;
   logic                  free;
   rsp_word_type          result;
   rsp_word_type          rsp_word;
   logic [INDEX_BITS-1:0] index;
   logic [INDEX_BITS-1:0] rsp_index;

   assign req_word.char_byte      = req_chan.char_byte;
   assign req_word.byte_present   = req_chan.byte_present;
   assign req_word.end_of_element = req_chan.end_of_element;

   assign advance = word_valid && (!closes || free);

   sdi_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_word   (req_word),
      .advance    (advance),
      .word_valid (word_valid),
      .word       (word)
   );

   sdi_element #(
      .INDEX_BITS (INDEX_BITS)
   ) u_element (
      .clock   (clock),
      .reset   (reset),
      .word    (word),
      .advance (advance),
      .closes  (closes),
      .result  (result),
      .index   (index)
   );

   sdi_out_stage #(
      .INDEX_BITS (INDEX_BITS)
   ) u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && closes),
      .result    (result),
      .index     (index),
      .free      (free),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_word  (rsp_word),
      .rsp_index (rsp_index)
   );

   assign rsp_chan.is_number      = rsp_word.is_number;
   assign rsp_chan.parsed_value   = rsp_word.parsed_value;
   assign rsp_chan.element_number = rsp_index;

endmodule
`default_nettype wire

>>> hdl/sdi_checker.sv
// Port-level checks for the strict decimal int64 parser, bound to the top level.
// Depends on sdi_pkg and strict_decimal_int64_parser_macros.svh.
`default_nettype none
`include "strict_decimal_int64_parser_macros.svh"
module sdi_checker
   import sdi_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic                  rsp_is_number,
   input wire logic signed [63:0]    rsp_parsed_value,
   input wire logic [INDEX_BITS-1:0] rsp_element_number
);

   logic [INDEX_BITS-1:0] expect_ff, expect_in;

   assign expect_in = (rsp_valid && rsp_ready) ? expect_ff + INDEX_BITS'(1) : expect_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= '0;
      end else begin
         expect_ff <= expect_in;
      end
   end

   `SDI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped while stalled")
   `SDI_ASSERT_IMPL(a_index_seq, clock, reset, rsp_valid, rsp_element_number == expect_ff, "element index out of sequence")
   `SDI_ASSERT_IMPL(a_exc_zero, clock, reset, rsp_valid && !rsp_is_number, rsp_parsed_value == 64'sd0, "exception word with nonzero value")
   `SDI_ASSERT_IMPL(a_reset_empty, clock, 1'b0, $past(reset), !rsp_valid, "rsp valid right after reset")

endmodule

bind strict_decimal_int64_parser sdi_checker #(
   .INDEX_BITS (INDEX_BITS)
) u_sdi_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_is_number      (rsp_chan.is_number),
   .rsp_parsed_value   (rsp_chan.parsed_value),
   .rsp_element_number (rsp_chan.element_number)
);
`default_nettype wire
